FILE: design/geodesic_range_bearing_assert.svh
// Assertion macros shared by the range and bearing RTL
`ifndef GEODESIC_RANGE_BEARING_ASSERT_SVH
`define GEODESIC_RANGE_BEARING_ASSERT_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define GRB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while aresetn is low
`define GRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/grb_pkg.sv
// Shared types, CORDIC angle table and fixed-point constants
package grb_pkg;

    localparam int TRIG_W = 34;
    typedef logic signed [TRIG_W-1:0] trig_t;

    typedef logic [31:0] bam_t;

    localparam int VEC_W = 45;
    typedef logic signed [VEC_W-1:0] vec_t;

    localparam int ISQ_STEPS = 31;
    localparam int RAD_W = 61;
    typedef logic [RAD_W-1:0] rad_t;
    typedef logic [30:0] root_t;

    localparam bam_t ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    localparam trig_t       GAIN_Q30      = 34'sd652032874;
    localparam logic [42:0] RECIP_45      = 43'd6254999482460;
    localparam logic [23:0] DIST_SCALE    = 24'd11066658;
    localparam rad_t        ONE_Q60       = 61'h1000000000000000;
    localparam logic [24:0] BRG_FULL_TURN = 25'd23592960;
    localparam logic [21:0] DIST_MAX      = 22'd2766665;

    localparam logic [1:0] REG_HOME_LAT = 2'd0;
    localparam logic [1:0] REG_HOME_LON = 2'd1;

endpackage

FILE: design/geodesic_range_bearing.sv
// Top level: haversine range and initial bearing pipeline against a home position
//
//  channel  dir  handshake              payload
//  s_       in   s_valid / s_ready      s_target_lat[30:0], s_target_lon[31:0]
//  m_       out  m_valid / m_ready      m_bearing[24:0], m_distance[21:0]
//  cfg_     in   cfg_valid / cfg_ready  cfg_index[1:0], cfg_data[31:0]
//
//  One position per cycle while the output is not stalled; the path runs through
//  two CORDIC chains in series and the 31-step square root.
//  aresetn clears the valid bits and the home registers to zero.
//  The whole pipeline advances while the output register is empty or taken;
//  a stalled output holds every stage, s_ready low.
`include "geodesic_range_bearing_assert.svh"
module geodesic_range_bearing #(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [30:0] s_target_lat,
    input  logic signed [31:0] s_target_lon,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [24:0]        m_bearing,
    output logic [21:0]        m_distance,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import grb_pkg::*;

    localparam int PIPE_DEPTH = 2 * CORDIC_ITERATIONS + 43;

    function automatic trig_t mul_q30(input trig_t a, input trig_t b);
        logic signed [2*TRIG_W-1:0] p;
        p = (2*TRIG_W)'(a) * (2*TRIG_W)'(b);
        return p[TRIG_W+29:30];
    endfunction

    logic               adv;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic signed [30:0] home_lat_reg;
    logic signed [31:0] home_lon_reg;

    trig_t lat1_reg, lat2_reg, dlat_reg, dlon_reg;
    bam_t  b_lat1, b_lat2, b_dlon, b_hlat, b_hlon;
    trig_t s1, c1, s2, c2, sdl, cdl, shl, chl, sho, cho;

    trig_t p1_y_reg, p1_t1_reg, p1_t2_reg, p1_cc_reg, p1_sho_reg, p1_cdl_reg;
    logic signed [2*TRIG_W-1:0] p1_shl2_reg;
    trig_t p2_y_reg, p2_x_reg, p2_tt_reg, p2_sho_reg;
    logic signed [2*TRIG_W-1:0] p2_shl2_reg;
    trig_t p3_y_reg, p3_x_reg;
    logic signed [2*TRIG_W-1:0] p3_a_reg;
    trig_t p4_y_reg, p4_x_reg;
    rad_t  p4_a_reg, p4_b_reg;
    rad_t  a_clamp;
    trig_t dly_y_reg [ISQ_STEPS];
    trig_t dly_x_reg [ISQ_STEPS];

    root_t root_a, root_b;
    bam_t  ang_brg, ang_dist;

    logic [30:0] th_clamp;
    logic [54:0] dist_wide;
    logic [41:0] brg_wide;
    logic [25:0] brg_next;
    logic [24:0] bearing_reg;
    logic [21:0] distance_reg;

    assign adv       = !valid_reg[PIPE_DEPTH-1] || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;
    assign m_valid   = valid_reg[PIPE_DEPTH-1];
    assign m_bearing  = bearing_reg;
    assign m_distance = distance_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            home_lat_reg <= '0;
            home_lon_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_HOME_LAT: home_lat_reg <= cfg_data[30:0];
                REG_HOME_LON: home_lon_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lat1_reg <= TRIG_W'(home_lat_reg);
            lat2_reg <= TRIG_W'(s_target_lat);
            dlat_reg <= TRIG_W'(s_target_lat) - TRIG_W'(home_lat_reg);
            dlon_reg <= TRIG_W'(s_target_lon) - TRIG_W'(home_lon_reg);
        end
    end

    grb_bam u_bam_lat1 (.aclk, .en(adv), .half(1'b0), .deg_in(lat1_reg), .bam_out(b_lat1));
    grb_bam u_bam_lat2 (.aclk, .en(adv), .half(1'b0), .deg_in(lat2_reg), .bam_out(b_lat2));
    grb_bam u_bam_dlon (.aclk, .en(adv), .half(1'b0), .deg_in(dlon_reg), .bam_out(b_dlon));
    grb_bam u_bam_hlat (.aclk, .en(adv), .half(1'b1), .deg_in(dlat_reg), .bam_out(b_hlat));
    grb_bam u_bam_hlon (.aclk, .en(adv), .half(1'b1), .deg_in(dlon_reg), .bam_out(b_hlon));

    grb_sincos #(.ITER(CORDIC_ITERATIONS)) u_sc_lat1 (
        .aclk, .en(adv), .angle_in(b_lat1), .sin_out(s1), .cos_out(c1));
    grb_sincos #(.ITER(CORDIC_ITERATIONS)) u_sc_lat2 (
        .aclk, .en(adv), .angle_in(b_lat2), .sin_out(s2), .cos_out(c2));
    grb_sincos #(.ITER(CORDIC_ITERATIONS)) u_sc_dlon (
        .aclk, .en(adv), .angle_in(b_dlon), .sin_out(sdl), .cos_out(cdl));
    grb_sincos #(.ITER(CORDIC_ITERATIONS)) u_sc_hlat (
        .aclk, .en(adv), .angle_in(b_hlat), .sin_out(shl), .cos_out(chl));
    grb_sincos #(.ITER(CORDIC_ITERATIONS)) u_sc_hlon (
        .aclk, .en(adv), .angle_in(b_hlon), .sin_out(sho), .cos_out(cho));

    always_comb begin
        if (p3_a_reg[2*TRIG_W-1]) begin
            a_clamp = '0;
        end else if (p3_a_reg > $signed({7'b0, ONE_Q60})) begin
            a_clamp = ONE_Q60;
        end else begin
            a_clamp = p3_a_reg[RAD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_y_reg    <= mul_q30(sdl, c2);
            p1_t1_reg   <= mul_q30(c1, s2);
            p1_t2_reg   <= mul_q30(s1, c2);
            p1_cc_reg   <= mul_q30(c1, c2);
            p1_shl2_reg <= (2*TRIG_W)'(shl) * (2*TRIG_W)'(shl);
            p1_sho_reg  <= sho;
            p1_cdl_reg  <= cdl;

            p2_y_reg    <= p1_y_reg;
            p2_x_reg    <= p1_t1_reg - mul_q30(p1_t2_reg, p1_cdl_reg);
            p2_tt_reg   <= mul_q30(p1_cc_reg, p1_sho_reg);
            p2_shl2_reg <= p1_shl2_reg;
            p2_sho_reg  <= p1_sho_reg;

            p3_y_reg <= p2_y_reg;
            p3_x_reg <= p2_x_reg;
            p3_a_reg <= p2_shl2_reg + (2*TRIG_W)'(p2_tt_reg) * (2*TRIG_W)'(p2_sho_reg);

            p4_y_reg <= p3_y_reg;
            p4_x_reg <= p3_x_reg;
            p4_a_reg <= a_clamp;
            p4_b_reg <= ONE_Q60 - a_clamp;

            dly_y_reg[0] <= p4_y_reg;
            dly_x_reg[0] <= p4_x_reg;
            for (int k = 1; k < ISQ_STEPS; k++) begin
                dly_y_reg[k] <= dly_y_reg[k-1];
                dly_x_reg[k] <= dly_x_reg[k-1];
            end
        end
    end

    grb_isqrt u_sqrt_a (.aclk, .en(adv), .rad_in(p4_a_reg), .root_out(root_a));
    grb_isqrt u_sqrt_b (.aclk, .en(adv), .rad_in(p4_b_reg), .root_out(root_b));

    grb_atan2 #(.ITER(CORDIC_ITERATIONS)) u_atan_brg (
        .aclk, .en(adv), .y_in(dly_y_reg[ISQ_STEPS-1]), .x_in(dly_x_reg[ISQ_STEPS-1]),
        .angle_out(ang_brg));
    grb_atan2 #(.ITER(CORDIC_ITERATIONS)) u_atan_dist (
        .aclk, .en(adv), .y_in(TRIG_W'(root_a)), .x_in(TRIG_W'(root_b)),
        .angle_out(ang_dist));

    always_comb begin
        if (ang_dist[31]) begin
            th_clamp = '0;
        end else if (ang_dist > 32'h40000000) begin
            th_clamp = 31'h40000000;
        end else begin
            th_clamp = ang_dist[30:0];
        end
        dist_wide = 55'(th_clamp) * 55'(DIST_SCALE) + (55'(1) << 31);
        brg_wide  = 42'(ang_brg) * 42'd360 + 42'd32768;
        brg_next  = brg_wide[41:16];
        if (brg_next >= 26'(BRG_FULL_TURN)) begin
            brg_next = brg_next - 26'(BRG_FULL_TURN);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            bearing_reg  <= brg_next[24:0];
            distance_reg <= dist_wide[53:32];
        end
    end

    `GRB_ASSERT_NOW(a_brg_range, m_valid, m_bearing < BRG_FULL_TURN, "bearing out of range")
    `GRB_ASSERT_NOW(a_dist_range, m_valid, m_distance <= DIST_MAX, "distance out of range")
    `GRB_ASSERT_NEXT(a_stall_hold, m_valid && !m_ready, $stable(valid_reg), "pipe moved in stall")
    `GRB_ASSERT_NEXT(a_accept_enter, s_valid && s_ready, valid_reg[0], "accepted item lost")

endmodule

FILE: design/grb_bam.sv
// Degrees*2^23 to 32-bit binary angle, rounded, three register stages
module grb_bam (
    input  logic          aclk,
    input  logic          en,
    input  logic          half,
    input  grb_pkg::trig_t deg_in,
    output grb_pkg::bam_t  bam_out
);
    import grb_pkg::*;

    logic [32:0] mag;
    logic [39:0] num_next;
    logic [39:0] num_reg;
    logic        neg_reg;
    logic        neg_b_reg;
    logic [62:0] plo_reg;
    logic [62:0] phi_reg;
    logic [82:0] prod;
    bam_t        quo;
    bam_t        bam_reg;

    always_comb begin
        mag = deg_in[TRIG_W-1] ? 33'(-deg_in) : 33'(deg_in);
        if (half) begin
            num_next = ({7'b0, mag} << 5) + 40'd22;
        end else begin
            num_next = ({7'b0, mag} << 6) + 40'd22;
        end
        prod = {phi_reg, 20'b0} + {20'b0, plo_reg};
        quo  = prod[79:48];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg   <= num_next;
            neg_reg   <= deg_in[TRIG_W-1];
            plo_reg   <= 63'(num_reg[19:0]) * 63'(RECIP_45);
            phi_reg   <= 63'(num_reg[39:20]) * 63'(RECIP_45);
            neg_b_reg <= neg_reg;
            bam_reg   <= neg_b_reg ? -quo : quo;
        end
    end

    assign bam_out = bam_reg;

endmodule

FILE: design/grb_sincos.sv
// Rotation-mode CORDIC, one iteration per register stage
module grb_sincos #(
    parameter int ITER = 24
) (
    input  logic           aclk,
    input  logic           en,
    input  grb_pkg::bam_t  angle_in,
    output grb_pkg::trig_t sin_out,
    output grb_pkg::trig_t cos_out
);
    import grb_pkg::*;

    trig_t      x_reg [ITER+1];
    trig_t      y_reg [ITER+1];
    trig_t      z_reg [ITER+1];
    logic [ITER:0] flip_reg;

    bam_t  quad;
    bam_t  rot;
    logic  flip;

    always_comb begin
        quad = angle_in + 32'h40000000;
        flip = quad[31];
        rot  = flip ? angle_in + 32'h80000000 : angle_in;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= {{(TRIG_W-32){rot[31]}}, rot};
            flip_reg[0] <= flip;
            for (int g = 0; g < ITER; g++) begin
                if (!z_reg[g][TRIG_W-1]) begin
                    x_reg[g+1] <= x_reg[g] - (y_reg[g] >>> g);
                    y_reg[g+1] <= y_reg[g] + (x_reg[g] >>> g);
                    z_reg[g+1] <= z_reg[g] - {{(TRIG_W-32){1'b0}}, ATAN_TAB[g]};
                end else begin
                    x_reg[g+1] <= x_reg[g] + (y_reg[g] >>> g);
                    y_reg[g+1] <= y_reg[g] - (x_reg[g] >>> g);
                    z_reg[g+1] <= z_reg[g] + {{(TRIG_W-32){1'b0}}, ATAN_TAB[g]};
                end
                flip_reg[g+1] <= flip_reg[g];
            end
        end
    end

    assign sin_out = flip_reg[ITER] ? -y_reg[ITER] : y_reg[ITER];
    assign cos_out = flip_reg[ITER] ? -x_reg[ITER] : x_reg[ITER];

endmodule

FILE: design/grb_isqrt.sv
// Digit-by-digit floor square root, one result bit per register stage
module grb_isqrt (
    input  logic          aclk,
    input  logic          en,
    input  grb_pkg::rad_t rad_in,
    output grb_pkg::root_t root_out
);
    import grb_pkg::*;

    rad_t rem_reg  [ISQ_STEPS];
    rad_t r_reg    [ISQ_STEPS];
    rad_t rem_next [ISQ_STEPS];
    rad_t r_next   [ISQ_STEPS];

    always_comb begin
        rad_t cur_rem;
        rad_t cur_r;
        rad_t bit_w;
        logic [RAD_W:0] trial;
        for (int k = 0; k < ISQ_STEPS; k++) begin
            if (k == 0) begin
                cur_rem = rad_in;
                cur_r   = '0;
            end else begin
                cur_rem = rem_reg[k-1];
                cur_r   = r_reg[k-1];
            end
            bit_w = rad_t'(1) << (RAD_W - 1 - 2 * k);
            trial = {1'b0, cur_r} + {1'b0, bit_w};
            if ({1'b0, cur_rem} >= trial) begin
                rem_next[k] = cur_rem - trial[RAD_W-1:0];
                r_next[k]   = (cur_r >> 1) + bit_w;
            end else begin
                rem_next[k] = cur_rem;
                r_next[k]   = cur_r >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < ISQ_STEPS; k++) begin
                rem_reg[k] <= rem_next[k];
                r_reg[k]   <= r_next[k];
            end
        end
    end

    assign root_out = r_reg[ISQ_STEPS-1][30:0];

endmodule

FILE: design/grb_atan2.sv
// Vectoring-mode CORDIC atan2 with two-stage normalize ahead of the iterations
module grb_atan2 #(
    parameter int ITER = 24
) (
    input  logic           aclk,
    input  logic           en,
    input  grb_pkg::trig_t y_in,
    input  grb_pkg::trig_t x_in,
    output grb_pkg::bam_t  angle_out
);
    import grb_pkg::*;

    vec_t             x1_reg;
    vec_t             y1_reg;
    logic [VEC_W-1:0] m1_reg;
    logic             zero1_reg;

    vec_t          x_reg [ITER+1];
    vec_t          y_reg [ITER+1];
    bam_t          z_reg [ITER+1];
    logic [ITER:0] zero_reg;

    vec_t             xa;
    vec_t             ya;
    logic [VEC_W-1:0] ma;
    vec_t             xb;
    vec_t             yb;
    logic [VEC_W-1:0] mb;
    bam_t             zb;

    always_comb begin
        int sa;
        int sb;
        xa = VEC_W'(x_in);
        ya = VEC_W'(y_in);
        ma = (xa[VEC_W-1] ? -xa : xa) | (ya[VEC_W-1] ? -ya : ya);
        for (int j = 0; j < 3; j++) begin
            sa = 32 >> j;
            if (ma < (VEC_W'(1) << (40 - sa))) begin
                ma = ma << sa;
                xa = xa <<< sa;
                ya = ya <<< sa;
            end
        end
        xb = x1_reg;
        yb = y1_reg;
        mb = m1_reg;
        for (int j = 0; j < 3; j++) begin
            sb = 4 >> j;
            if (mb < (VEC_W'(1) << (40 - sb))) begin
                mb = mb << sb;
                xb = xb <<< sb;
                yb = yb <<< sb;
            end
        end
        zb = '0;
        if (xb[VEC_W-1]) begin
            xb = -xb;
            yb = -yb;
            zb = 32'h80000000;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg      <= xa;
            y1_reg      <= ya;
            m1_reg      <= ma;
            zero1_reg   <= (x_in == '0) && (y_in == '0);
            x_reg[0]    <= xb;
            y_reg[0]    <= yb;
            z_reg[0]    <= zb;
            zero_reg[0] <= zero1_reg;
            for (int g = 0; g < ITER; g++) begin
                if (!y_reg[g][VEC_W-1] && (y_reg[g] != '0)) begin
                    x_reg[g+1] <= x_reg[g] + (y_reg[g] >>> g);
                    y_reg[g+1] <= y_reg[g] - (x_reg[g] >>> g);
                    z_reg[g+1] <= z_reg[g] + ATAN_TAB[g];
                end else begin
                    x_reg[g+1] <= x_reg[g] - (y_reg[g] >>> g);
                    y_reg[g+1] <= y_reg[g] + (x_reg[g] >>> g);
                    z_reg[g+1] <= z_reg[g] - ATAN_TAB[g];
                end
                zero_reg[g+1] <= zero_reg[g];
            end
        end
    end

    assign angle_out = zero_reg[ITER] ? '0 : z_reg[ITER];

endmodule
